// ===== rtl/core/arpc_pkg.sv =====
// Shared types and constants for the ARP cache table.
// No dependencies; compiled first.
`default_nettype none

package arpc_pkg;

	localparam int unsigned DEF_ENTRIES = 16;
	localparam int unsigned IP_W        = 32;
	localparam int unsigned MAC_W       = 48;

	typedef enum logic [0:0] {
		CMD_UPDATE = 1'b0,
		CMD_LOOKUP = 1'b1
	} cmd_t;

	typedef struct packed {
		cmd_t             cmd;
		logic [IP_W-1:0]  ip_addr;
		logic [MAC_W-1:0] mac_addr;
	} req_t;

	typedef struct packed {
		logic             ok;
		logic [MAC_W-1:0] mac_out;
	} rsp_t;

endpackage

`default_nettype wire

// ===== rtl/core/arpc_stream_if.sv =====
// Valid/ready channel carrying one payload type per transaction.
// Payload types come from arpc_pkg.
`default_nettype none

interface arpc_stream_if #(
	parameter type T = logic
);
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/arpc_ram.sv =====
// Simple dual-port RAM: one write port, one read port, registered read data.
// Standalone; used for the address and MAC columns of the table.
`default_nettype none

module arpc_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 16
) (
	input  wire logic                                      clk,
	input  wire logic                                      we,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                          wdata,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                          rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

// ===== rtl/core/arp_cache_table_core.sv =====
// ARP cache table: IPv4 to MAC map with ENTRIES slots, no eviction. The table
// is scanned one slot per cycle through the single read port of the address
// and MAC memories (registered read data), then a drain state, then a resolve
// step does the lookup or update and writes back. A new transaction is accepted
// only when idle, after the last one has resolved, even while its result still
// waits on rsp; the resolve step waits until rsp is free. Valid marks are
// flip-flops cleared by reset, so no clearing pass is needed. Update gives ok=1
// when stored, ok=0 when the table is full; lookup gives ok=1 and the MAC on a
// hit.
// Depends on arpc_pkg, arpc_stream_if and arpc_ram.
`default_nettype none

module arp_cache_table_core #(
	parameter int unsigned ENTRIES = arpc_pkg::DEF_ENTRIES
) (
	input wire logic clk,
	input wire logic arst_n,
	arpc_stream_if.sink   req,
	arpc_stream_if.source rsp
);

	localparam int unsigned IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_DONE
	} state_t;

	state_t                      state_q;
	arpc_pkg::cmd_t              cmd_q;
	logic [arpc_pkg::IP_W-1:0]   ip_q;
	logic [arpc_pkg::MAC_W-1:0]  mac_q;
	logic [IW-1:0]               cnt_q;
	logic                        rd_vld_s1;
	logic [IW-1:0]               rd_idx_s1;
	logic                        found_q;
	logic [IW-1:0]               hit_idx_q;
	logic [arpc_pkg::MAC_W-1:0]  hit_mac_q;
	logic                        free_q;
	logic [IW-1:0]               free_idx_q;
	logic [ENTRIES-1:0]          valid_q;
	logic                        rsp_valid_q;
	logic                        rsp_ok_q;
	logic [arpc_pkg::MAC_W-1:0]  rsp_mac_q;

	logic [arpc_pkg::IP_W-1:0]   rd_ip;
	logic [arpc_pkg::MAC_W-1:0]  rd_mac;
	logic                        out_free;
	logic                        resolve;
	logic                        is_upd;
	logic                        ip_we;
	logic                        mac_we;
	logic [IW-1:0]               wr_idx;
	logic                        rd_hit;
	logic                        rd_free;

	assign out_free = !rsp_valid_q || rsp.ready;
	assign resolve  = (state_q == ST_DONE) && out_free;
	assign is_upd   = (cmd_q == arpc_pkg::CMD_UPDATE);
	assign mac_we   = resolve && is_upd && (found_q || free_q);
	assign ip_we    = resolve && is_upd && !found_q && free_q;
	assign wr_idx   = found_q ? hit_idx_q : free_idx_q;
	assign rd_hit   = rd_vld_s1 && valid_q[rd_idx_s1] && (rd_ip == ip_q);
	assign rd_free  = rd_vld_s1 && !valid_q[rd_idx_s1];

	assign req.ready     = (state_q == ST_IDLE);
	assign rsp.valid     = rsp_valid_q;
	assign rsp.data.ok      = rsp_ok_q;
	assign rsp.data.mac_out = rsp_mac_q;

	arpc_ram #(
		.WIDTH (arpc_pkg::IP_W),
		.DEPTH (ENTRIES)
	) u_ip_ram (
		.clk   (clk),
		.we    (ip_we),
		.waddr (wr_idx),
		.wdata (ip_q),
		.raddr (cnt_q),
		.rdata (rd_ip)
	);

	arpc_ram #(
		.WIDTH (arpc_pkg::MAC_W),
		.DEPTH (ENTRIES)
	) u_mac_ram (
		.clk   (clk),
		.we    (mac_we),
		.waddr (wr_idx),
		.wdata (mac_q),
		.raddr (cnt_q),
		.rdata (rd_mac)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			rd_vld_s1   <= 1'b0;
			found_q     <= 1'b0;
			free_q      <= 1'b0;
			valid_q     <= '0;
			rsp_valid_q <= 1'b0;
			rsp_ok_q    <= 1'b0;
			rsp_mac_q   <= '0;
		end else begin
			if (resolve) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_valid_q && rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
			rd_vld_s1 <= (state_q == ST_SCAN);
			if (rd_hit && !found_q) begin
				found_q <= 1'b1;
			end
			if (rd_free && !free_q) begin
				free_q <= 1'b1;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (req.valid) begin
						cnt_q   <= '0;
						found_q <= 1'b0;
						free_q  <= 1'b0;
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (cnt_q == IW'(ENTRIES - 1)) begin
						state_q <= ST_DRAIN;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_DRAIN: begin
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (out_free) begin
						if (is_upd) begin
							rsp_ok_q  <= found_q || free_q;
							rsp_mac_q <= '0;
						end else begin
							rsp_ok_q  <= found_q;
							rsp_mac_q <= found_q ? hit_mac_q : '0;
						end
						if (ip_we) begin
							valid_q[free_idx_q] <= 1'b1;
						end
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		rd_idx_s1 <= cnt_q;
		if (req.valid && req.ready) begin
			cmd_q <= req.data.cmd;
			ip_q  <= req.data.ip_addr;
			mac_q <= req.data.mac_addr;
		end
		if (rd_hit && !found_q) begin
			hit_idx_q <= rd_idx_s1;
			hit_mac_q <= rd_mac;
		end
		if (rd_free && !free_q) begin
			free_idx_q <= rd_idx_s1;
		end
	end

	a_new_slot_valid: assert property (@(posedge clk) disable iff (!arst_n)
		ip_we |=> valid_q[$past(free_idx_q)])
		else $error("claimed slot not marked valid");

	a_hit_is_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(found_q && state_q == ST_DONE) |-> valid_q[hit_idx_q])
		else $error("hit recorded on an invalid slot");

	a_no_dup_insert: assert property (@(posedge clk) disable iff (!arst_n)
		ip_we |-> (!found_q && !valid_q[free_idx_q]))
		else $error("insert would create a duplicate or overwrite a valid slot");

	a_mac_needs_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid_q && rsp_mac_q != '0) |-> rsp_ok_q)
		else $error("MAC returned without ok");

endmodule

`default_nettype wire

// ===== dv/testbench.sv =====
// Self-checking testbench for arp_cache_table_core: a directed table, then random
// update/lookup transactions checked against a behavioral table model.
// Depends on arpc_pkg, arpc_stream_if and the core RTL.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import arpc_pkg::*;

	localparam int unsigned N         = DEF_ENTRIES;
	localparam int          RAND_TXNS = 1075;

	typedef struct {
		cmd_t             cmd;
		logic [IP_W-1:0]  ip;
		logic [MAC_W-1:0] mac;
		bit               fixed;
		rsp_t             want;
	} step_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	arpc_stream_if #(.T(req_t)) req_if ();
	arpc_stream_if #(.T(rsp_t)) rsp_if ();

	arp_cache_table_core #(.ENTRIES(N)) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_if),
		.rsp(rsp_if)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// behavioral copy of the table
	bit               tbl_valid [N];
	logic [IP_W-1:0]  tbl_ip [N];
	logic [MAC_W-1:0] tbl_mac [N];

	rsp_t      pending_answers [$];
	step_row_t script [$];
	int        err_cnt = 0;
	int        sink_hold = 0;
	bit        calm = 1'b0;

	function automatic rsp_t arp_resolve(req_t r);
		int   hit;
		int   spare;
		rsp_t o;
		hit = -1;
		spare = -1;
		o = '0;
		for (int i = 0; i < N; i++) begin
			if (hit < 0 && tbl_valid[i] && tbl_ip[i] == r.ip_addr)
				hit = i;
			if (spare < 0 && !tbl_valid[i])
				spare = i;
		end
		if (r.cmd == CMD_UPDATE) begin
			if (hit < 0 && spare >= 0) begin
				tbl_valid[spare] = 1'b1;
				tbl_ip[spare] = r.ip_addr;
				hit = spare;
			end
			if (hit >= 0) begin
				tbl_mac[hit] = r.mac_addr;
				o.ok = 1'b1;
			end
		end else if (hit >= 0) begin
			o.ok = 1'b1;
			o.mac_out = tbl_mac[hit];
		end
		return o;
	endfunction

	function automatic int pick_gap();
		int r;
		if (calm)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 40)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	function automatic step_row_t mk_row(cmd_t c, logic [IP_W-1:0] ip, logic [MAC_W-1:0] mac,
			bit fixed, logic ok, logic [MAC_W-1:0] mac_out);
		step_row_t s;
		s.cmd = c;
		s.ip = ip;
		s.mac = mac;
		s.fixed = fixed;
		s.want.ok = ok;
		s.want.mac_out = mac_out;
		return s;
	endfunction

	function automatic req_t rand_req();
		req_t          r;
		int            r_sel;
		int            live [$];
		r.cmd = cmd_t'($urandom_range(0, 1));
		r.mac_addr = {16'($urandom), 32'($urandom)};
		r.ip_addr = $urandom;
		for (int i = 0; i < N; i++)
			if (tbl_valid[i])
				live.push_back(i);
		r_sel = $urandom_range(0, 99);
		if (live.size() != 0 && r_sel < 70) begin
			r.ip_addr = tbl_ip[live[$urandom_range(0, live.size() - 1)]];
			if (r_sel >= 55)
				r.ip_addr = r.ip_addr ^ (32'h1 << $urandom_range(0, 31));
		end
		return r;
	endfunction

	task automatic report_miss(string what, logic [MAC_W-1:0] want, logic [MAC_W-1:0] got);
		err_cnt++;
		if (err_cnt <= 10)
			$display("%0t: mismatch on %s: expected %h, got %h", $realtime, what, want, got);
	endtask

	task automatic push_txn(req_t r, bit fixed, rsp_t want, int gap_after);
		rsp_t p;
		req_if.valid <= 1'b1;
		req_if.data <= r;
		@(posedge clk);
		while (!req_if.ready)
			@(posedge clk);
		p = arp_resolve(r);
		pending_answers.push_back(fixed ? want : p);
		if (gap_after > 0) begin
			req_if.valid <= 1'b0;
			repeat (gap_after) @(posedge clk);
		end
	endtask

	// response sink with random backpressure
	always @(posedge clk) begin
		if (arst_n) begin
			if (sink_hold > 0) begin
				sink_hold <= sink_hold - 1;
				rsp_if.ready <= 1'b0;
			end else begin
				rsp_if.ready <= 1'b1;
				if ($urandom_range(0, 2) == 0)
					sink_hold <= pick_gap();
			end
		end
	end

	always @(posedge clk) begin
		rsp_t got;
		rsp_t want;
		if (arst_n && rsp_if.valid && rsp_if.ready) begin
			got = rsp_if.data;
			if (pending_answers.size() == 0) begin
				report_miss("unrequested transaction", '0, got.mac_out);
			end else begin
				want = pending_answers.pop_front();
				if (got.ok !== want.ok)
					report_miss("ok", MAC_W'(want.ok), MAC_W'(got.ok));
				if (got.mac_out !== want.mac_out)
					report_miss("mac_out", want.mac_out, got.mac_out);
			end
		end
	end

	initial begin
		req_t r;
		rsp_t none;
		req_if.valid = 1'b0;
		req_if.data = '0;
		rsp_if.ready = 1'b0;
		none = '0;

		script.push_back(mk_row(CMD_LOOKUP, '0, '1, 1, 1'b0, '0));
		script.push_back(mk_row(CMD_UPDATE, '0, '0, 1, 1'b1, '0));
		script.push_back(mk_row(CMD_UPDATE, '1, '1, 1, 1'b1, '0));
		script.push_back(mk_row(CMD_LOOKUP, '0, '0, 1, 1'b1, '0));
		script.push_back(mk_row(CMD_LOOKUP, '1, '0, 1, 1'b1, '1));
		script.push_back(mk_row(CMD_UPDATE, '0, 48'hA5A5_5A5A_0F0F, 1, 1'b1, '0));
		script.push_back(mk_row(CMD_LOOKUP, '0, '0, 0, 1'b0, '0));
		script.push_back(mk_row(CMD_LOOKUP, 32'h1, '0, 1, 1'b0, '0));
		for (int i = 2; i < N; i++)
			script.push_back(mk_row(CMD_UPDATE, 32'h0A00_0000 + i * 32'h0103_0507,
				48'h0200_0000_0000 | 48'(i * 7919), 0, 1'b0, '0));
		// table is full from here on
		script.push_back(mk_row(CMD_UPDATE, 32'hC0A8_0101, 48'h1234_5678_9ABC, 1, 1'b0, '0));
		script.push_back(mk_row(CMD_LOOKUP, 32'hC0A8_0101, '0, 1, 1'b0, '0));
		script.push_back(mk_row(CMD_UPDATE, '1, 48'h0123_4567_89AB, 1, 1'b1, '0));

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (script[k]) begin
			r.cmd = script[k].cmd;
			r.ip_addr = script[k].ip;
			r.mac_addr = script[k].mac;
			push_txn(r, script[k].fixed, script[k].want, pick_gap());
		end

		for (int n = 0; n < RAND_TXNS; n++) begin
			calm = (n % 200) >= 160;
			push_txn(rand_req(), 0, none, pick_gap());
		end
		req_if.valid <= 1'b0;
		calm = 1'b0;

		while (pending_answers.size() != 0)
			@(posedge clk);
		repeat (N + 20) @(posedge clk);
		if (err_cnt == 0)
			$display("arp_cache_table_core verification clean");
		else
			$display("arp_cache_table_core verification failed");
		$finish;
	end

	initial begin
		#10_000_000;
		$display("arp_cache_table_core verification failed");
		$finish;
	end

endmodule
